[rtl/gmcp_pkg.sv]
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared types, sizes and helpers of the grid path search block.
// ----------------------------------------------------------------------------
package gmcp_pkg;

	localparam int GRID_SIDE  = 8;
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int RC_W       = $clog2(GRID_SIDE);
	localparam int POS_W      = $clog2(CELL_COUNT);
	localparam int COST_W     = 14;
	localparam int CELL_W     = 8;
	localparam int CFG_W      = 3;
	localparam int CFG_IDX_W  = 2;

	typedef logic [RC_W-1:0]   rc_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [POS_W:0]    scan_t;
	typedef logic [COST_W-1:0] cost_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [CFG_W-1:0]  coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_ROW = 2'd0,
		CFG_START_COL = 2'd1,
		CFG_GOAL_ROW  = 2'd2,
		CFG_GOAL_COL  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_EAST  = 2'd0,
		DIR_SOUTH = 2'd1,
		DIR_WEST  = 2'd2,
		DIR_NORTH = 2'd3
	} dir_t;

	function automatic pos_t cell_index(rc_t row, rc_t col);
		return pos_t'(pos_t'(row) * pos_t'(GRID_SIDE) + pos_t'(col));
	endfunction

endpackage

[rtl/gmcp_if.sv]
// ----------------------------------------------------------------------------
// gmcp_if
// Valid/ready channels for grid cells in and search results out.
// ----------------------------------------------------------------------------
interface gmcp_in_if;
	logic                 valid;
	logic                 ready;
	gmcp_pkg::cell_t      cell_cost;
	logic                 last_cell;

	modport source (output valid, output cell_cost, output last_cell, input ready);
	modport sink   (input valid, input cell_cost, input last_cell, output ready);
endinterface

interface gmcp_out_if;
	logic                 valid;
	logic                 ready;
	gmcp_pkg::cost_t      path_cost;
	logic                 path_found;

	modport source (output valid, output path_cost, output path_found, input ready);
	modport sink   (input valid, input path_cost, input path_found, output ready);
endinterface

[rtl/gmcp_ram.sv]
// ----------------------------------------------------------------------------
// gmcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gmcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/gmcp_add_cmp.sv]
// ----------------------------------------------------------------------------
// gmcp_add_cmp
// Shared add-and-compare unit: base plus addend, checked against a limit.
// ----------------------------------------------------------------------------
module gmcp_add_cmp (
	input  gmcp_pkg::cost_t base,
	input  gmcp_pkg::cell_t addend,
	input  gmcp_pkg::cost_t limit,
	output gmcp_pkg::cost_t sum,
	output logic            less
);

	always_comb begin
		sum  = gmcp_pkg::cost_t'(base + gmcp_pkg::cost_t'(addend));
		less = (sum < limit);
	end

endmodule

[rtl/grid_min_cost_path_core.sv]
// ----------------------------------------------------------------------------
// grid_min_cost_path_core
// Least-cost 4-neighbour path search over a loaded grid of cell costs.
// ----------------------------------------------------------------------------
// Cells arrive on cell_in in row-major order, one item per cycle while the
// block is loading; a cost of zero is a wall. The item with last_cell set
// starts the search and nothing more is accepted until it ends. One result
// item (path_cost, path_found) leaves on result_out for each such search;
// path_cost is zero when the goal cannot be reached.
// The search repeatedly sweeps the per-cell best-sum RAM for the nearest
// unsettled cell (one RAM read and one pass through the shared adder and
// comparator per cell), then relaxes its four neighbours. Start and goal
// registers are written over cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce it. Reset
// returns to loading at the first cell, start 0,0 and goal 7,7. A stalled
// receiver holds the result in the output register; the next grid may
// load meanwhile, but its search waits to report.
// ----------------------------------------------------------------------------
module grid_min_cost_path_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gmcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  gmcp_pkg::coord_t             cfg_data,
	gmcp_in_if.sink                      cell_in,
	gmcp_out_if.source                   result_out
);

	typedef enum logic [6:0] {
		S_LOAD  = 7'b0000001,
		S_INIT  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_PICK  = 7'b0001000,
		S_NB_RD = 7'b0010000,
		S_NB_WR = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                                state_q;
	gmcp_pkg::coord_t                      start_row_q, start_col_q, goal_row_q, goal_col_q;
	gmcp_pkg::pos_t                        load_cnt_q;
	logic [gmcp_pkg::CELL_COUNT-1:0]       visited_q, reached_q;
	gmcp_pkg::scan_t                       scan_q;
	gmcp_pkg::rc_t                         scan_row_q, scan_col_q;
	logic                                  pend_s1;
	gmcp_pkg::pos_t                        idx_s1;
	gmcp_pkg::rc_t                         row_s1, col_s1;
	logic                                  have_q;
	gmcp_pkg::cost_t                       lo_q;
	gmcp_pkg::pos_t                        u_q;
	gmcp_pkg::rc_t                         u_row_q, u_col_q;
	gmcp_pkg::dir_t                        dir_q;
	gmcp_pkg::pos_t                        v_s1;
	logic                                  found_q;
	gmcp_pkg::cost_t                       res_cost_q;
	logic                                  out_valid_q;
	gmcp_pkg::cost_t                       out_cost_q;
	logic                                  out_found_q;

	logic                                  cell_acc, range_ok, out_free;
	gmcp_pkg::pos_t                        start_pos, goal_pos;
	gmcp_pkg::rc_t                         nb_row, nb_col;
	logic                                  nb_edge, nb_ok;
	gmcp_pkg::pos_t                        nb_pos;
	logic                                  sum_we;
	gmcp_pkg::pos_t                        sum_waddr, sum_raddr;
	gmcp_pkg::cost_t                       sum_wdata, sum_rd;
	gmcp_pkg::cell_t                       cost_rd;
	gmcp_pkg::cost_t                       unit_base, unit_limit, unit_sum;
	gmcp_pkg::cell_t                       unit_addend;
	logic                                  unit_less;
	logic                                  take, relax_ok, scan_end, last_dir;

	assign cell_in.ready         = (state_q == S_LOAD);
	assign cell_acc              = cell_in.valid && cell_in.ready;
	assign result_out.valid      = out_valid_q;
	assign result_out.path_cost  = out_cost_q;
	assign result_out.path_found = out_found_q;
	assign out_free              = !out_valid_q || result_out.ready;

	assign range_ok = (int'(start_row_q) < gmcp_pkg::GRID_SIDE)
		&& (int'(start_col_q) < gmcp_pkg::GRID_SIDE)
		&& (int'(goal_row_q) < gmcp_pkg::GRID_SIDE)
		&& (int'(goal_col_q) < gmcp_pkg::GRID_SIDE);
	assign start_pos = gmcp_pkg::cell_index(gmcp_pkg::rc_t'(start_row_q),
		gmcp_pkg::rc_t'(start_col_q));
	assign goal_pos  = gmcp_pkg::cell_index(gmcp_pkg::rc_t'(goal_row_q),
		gmcp_pkg::rc_t'(goal_col_q));

	// Neighbour of the settled cell in the current direction
	always_comb begin
		nb_row  = u_row_q;
		nb_col  = u_col_q;
		nb_edge = 1'b0;
		unique case (dir_q)
			gmcp_pkg::DIR_EAST: begin
				nb_edge = (u_col_q == gmcp_pkg::rc_t'(gmcp_pkg::GRID_SIDE - 1));
				nb_col  = gmcp_pkg::rc_t'(u_col_q + 1'b1);
			end
			gmcp_pkg::DIR_SOUTH: begin
				nb_edge = (u_row_q == gmcp_pkg::rc_t'(gmcp_pkg::GRID_SIDE - 1));
				nb_row  = gmcp_pkg::rc_t'(u_row_q + 1'b1);
			end
			gmcp_pkg::DIR_WEST: begin
				nb_edge = (u_col_q == '0);
				nb_col  = gmcp_pkg::rc_t'(u_col_q - 1'b1);
			end
			gmcp_pkg::DIR_NORTH: begin
				nb_edge = (u_row_q == '0);
				nb_row  = gmcp_pkg::rc_t'(u_row_q - 1'b1);
			end
			default: begin
				nb_edge = 1'b1;
			end
		endcase
		nb_pos = gmcp_pkg::cell_index(nb_row, nb_col);
		nb_ok  = !nb_edge && !visited_q[nb_pos];
	end

	// Share the adder and comparator between the sweep and the relaxation
	always_comb begin
		if (state_q == S_NB_WR) begin
			unit_base   = lo_q;
			unit_addend = cost_rd;
			unit_limit  = sum_rd;
		end else begin
			unit_base   = sum_rd;
			unit_addend = '0;
			unit_limit  = lo_q;
		end
	end

	gmcp_add_cmp u_unit (
		.base   (unit_base),
		.addend (unit_addend),
		.limit  (unit_limit),
		.sum    (unit_sum),
		.less   (unit_less)
	);

	assign take     = pend_s1 && reached_q[idx_s1] && !visited_q[idx_s1]
		&& (!have_q || unit_less);
	assign relax_ok = (cost_rd != '0) && (!reached_q[v_s1] || unit_less);
	assign scan_end = (scan_q == gmcp_pkg::scan_t'(gmcp_pkg::CELL_COUNT));
	assign last_dir = (dir_q == gmcp_pkg::DIR_NORTH);

	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = v_s1;
		sum_wdata = unit_sum;
		if (state_q == S_INIT) begin
			sum_we    = 1'b1;
			sum_waddr = start_pos;
			sum_wdata = '0;
		end else if (state_q == S_NB_WR) begin
			sum_we = relax_ok;
		end
		sum_raddr = (state_q == S_SCAN) ? scan_q[gmcp_pkg::POS_W-1:0] : nb_pos;
	end

	gmcp_ram #(
		.WIDTH (gmcp_pkg::CELL_W),
		.DEPTH (gmcp_pkg::CELL_COUNT)
	) u_cost_ram (
		.clk   (clk),
		.we    (cell_acc),
		.waddr (load_cnt_q),
		.wdata (cell_in.cell_cost),
		.raddr (nb_pos),
		.rdata (cost_rd)
	);

	gmcp_ram #(
		.WIDTH (gmcp_pkg::COST_W),
		.DEPTH (gmcp_pkg::CELL_COUNT)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= '0;
			start_col_q <= '0;
			goal_row_q  <= gmcp_pkg::coord_t'(7);
			goal_col_q  <= gmcp_pkg::coord_t'(7);
		end else if (cfg_we) begin
			unique case (gmcp_pkg::cfg_idx_t'(cfg_index))
				gmcp_pkg::CFG_START_ROW: start_row_q <= cfg_data;
				gmcp_pkg::CFG_START_COL: start_col_q <= cfg_data;
				gmcp_pkg::CFG_GOAL_ROW:  goal_row_q  <= cfg_data;
				gmcp_pkg::CFG_GOAL_COL:  goal_col_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			visited_q   <= '0;
			reached_q   <= '0;
			scan_q      <= '0;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			pend_s1     <= 1'b0;
			have_q      <= 1'b0;
			dir_q       <= gmcp_pkg::DIR_EAST;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (cell_acc) begin
						if (load_cnt_q == gmcp_pkg::pos_t'(gmcp_pkg::CELL_COUNT - 1)) begin
							load_cnt_q <= '0;
						end else begin
							load_cnt_q <= gmcp_pkg::pos_t'(load_cnt_q + 1'b1);
						end
						if (cell_in.last_cell) begin
							load_cnt_q <= '0;
							if (range_ok) begin
								state_q <= S_INIT;
							end else begin
								found_q <= 1'b0;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_INIT: begin
					visited_q            <= '0;
					reached_q            <= '0;
					reached_q[start_pos] <= 1'b1;
					scan_q               <= '0;
					scan_row_q           <= '0;
					scan_col_q           <= '0;
					pend_s1              <= 1'b0;
					have_q               <= 1'b0;
					state_q              <= S_SCAN;
				end
				S_SCAN: begin
					if (!scan_end) begin
						pend_s1 <= 1'b1;
						scan_q  <= gmcp_pkg::scan_t'(scan_q + 1'b1);
						if (scan_col_q == gmcp_pkg::rc_t'(gmcp_pkg::GRID_SIDE - 1)) begin
							scan_col_q <= '0;
							scan_row_q <= gmcp_pkg::rc_t'(scan_row_q + 1'b1);
						end else begin
							scan_col_q <= gmcp_pkg::rc_t'(scan_col_q + 1'b1);
						end
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_PICK;
						end
					end
					if (take) begin
						have_q  <= 1'b1;
						lo_q    <= sum_rd;
						u_q     <= idx_s1;
						u_row_q <= row_s1;
						u_col_q <= col_s1;
					end
				end
				S_PICK: begin
					if (!have_q) begin
						found_q <= 1'b0;
						state_q <= S_DONE;
					end else if (u_q == goal_pos) begin
						found_q    <= 1'b1;
						res_cost_q <= lo_q;
						state_q    <= S_DONE;
					end else begin
						visited_q[u_q] <= 1'b1;
						dir_q          <= gmcp_pkg::DIR_EAST;
						state_q        <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					if (nb_ok) begin
						v_s1    <= nb_pos;
						state_q <= S_NB_WR;
					end else if (last_dir) begin
						scan_q     <= '0;
						scan_row_q <= '0;
						scan_col_q <= '0;
						have_q     <= 1'b0;
						state_q    <= S_SCAN;
					end else begin
						dir_q <= gmcp_pkg::dir_t'(dir_q + 1'b1);
					end
				end
				S_NB_WR: begin
					if (relax_ok) begin
						reached_q[v_s1] <= 1'b1;
					end
					if (last_dir) begin
						scan_q     <= '0;
						scan_row_q <= '0;
						scan_col_q <= '0;
						have_q     <= 1'b0;
						state_q    <= S_SCAN;
					end else begin
						dir_q   <= gmcp_pkg::dir_t'(dir_q + 1'b1);
						state_q <= S_NB_RD;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Scan pipeline and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !scan_end) begin
			idx_s1 <= scan_q[gmcp_pkg::POS_W-1:0];
			row_s1 <= scan_row_q;
			col_s1 <= scan_col_q;
		end
		if (state_q == S_DONE && out_free) begin
			out_found_q <= found_q;
			out_cost_q  <= found_q ? res_cost_q : '0;
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks grid_min_cost_path_core: loads grids of cell costs over cell_in and
// compares every search result on result_out with a cheapest-route solver
// kept alongside the block. Covers route end corners, walls, short and long
// loads, back-pressure from a stalled receiver, and random grids.
// ----------------------------------------------------------------------------
module testbench;
	import gmcp_pkg::*;

	localparam int          CLK_PERIOD    = 4;
	localparam int          RESET_CYCLES  = 5;
	localparam int          IDLE_PCT      = 20;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          TAIL_CYCLES   = 64;
	localparam int          HOLD_CYCLES   = 12000;
	localparam int          RANDOM_ITEMS  = 1850;
	localparam int          LIMIT_CYCLES  = 2000000;
	localparam int unsigned NO_SUM        = 32'hFFFF_FFFF;

	typedef struct packed {
		cost_t cost;
		logic  found;
	} route_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	coord_t   cfg_data;

	gmcp_in_if  cell_bus ();
	gmcp_out_if result_bus ();

	grid_min_cost_path_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_in    (cell_bus.sink),
		.result_out (result_bus.source)
	);

	// shadow of the block's grid and route ends
	cell_t  grid_cost [CELL_COUNT];
	pos_t   fill_ptr = '0;
	coord_t start_r = 3'd0, start_c = 3'd0, goal_r = 3'd7, goal_c = 3'd7;

	route_t route_q [$];

	bit calm        = 1'b0;
	int hold_left   = 0;
	int hold_asked  = 0;
	int hold_given  = 0;
	int cycle_count = 0;
	int failures    = 0;
	int searches    = 0;
	int reached     = 0;
	int blocked     = 0;
	int cells_sent  = 0;
	int stall_count = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, route_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// least total cost over 4-neighbour moves; walls are never entered
	function automatic route_t solve_route();
		int unsigned best_sum [CELL_COUNT];
		bit          settled  [CELL_COUNT];
		int unsigned lo;
		int          i, d, src, dst, here, row, col, nrow, ncol, next;
		route_t      res;
		src = int'(start_r) * GRID_SIDE + int'(start_c);
		dst = int'(goal_r) * GRID_SIDE + int'(goal_c);
		for (i = 0; i < CELL_COUNT; i++) begin
			best_sum[i] = NO_SUM;
			settled[i]  = 1'b0;
		end
		best_sum[src] = 0;
		while (1) begin
			here = -1;
			lo   = NO_SUM;
			for (i = 0; i < CELL_COUNT; i++) begin
				if (!settled[i] && best_sum[i] < lo) begin
					lo   = best_sum[i];
					here = i;
				end
			end
			if (here < 0 || here == dst)
				break;
			settled[here] = 1'b1;
			row = here / GRID_SIDE;
			col = here % GRID_SIDE;
			for (d = 0; d < 4; d++) begin
				nrow = row;
				ncol = col;
				case (dir_t'(d))
					DIR_EAST:  ncol = col + 1;
					DIR_SOUTH: nrow = row + 1;
					DIR_WEST:  ncol = col - 1;
					default:   nrow = row - 1;
				endcase
				if (nrow >= 0 && ncol >= 0 && nrow < GRID_SIDE && ncol < GRID_SIDE) begin
					next = nrow * GRID_SIDE + ncol;
					if (!settled[next] && grid_cost[next] != '0 &&
					    lo + grid_cost[next] < best_sum[next])
						best_sum[next] = lo + grid_cost[next];
				end
			end
		end
		res.found = (best_sum[dst] != NO_SUM);
		res.cost  = res.found ? cost_t'(best_sum[dst]) : '0;
		return res;
	endfunction

	task automatic take_cell(cell_t cost, logic last);
		grid_cost[fill_ptr] = cost;
		fill_ptr            = fill_ptr + 1'b1;
		cells_sent++;
		if (last) begin
			fill_ptr = '0;
			route_q.push_back(solve_route());
			searches++;
		end
	endtask

	task automatic send_cell(cell_t cost, logic last);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			cell_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cell_bus.valid     <= 1'b1;
		cell_bus.cell_cost <= cost;
		cell_bus.last_cell <= last;
		@(posedge clk);
		while (!cell_bus.ready)
			@(posedge clk);
		take_cell(cost, last);
	endtask

	task automatic drain_results();
		cell_bus.valid <= 1'b0;
		@(posedge clk);
		while (route_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, coord_t value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_START_ROW: start_r = value;
			CFG_START_COL: start_c = value;
			CFG_GOAL_ROW:  goal_r  = value;
			default:       goal_c  = value;
		endcase
	endtask

	// registers only change once the block has gone quiet
	task automatic move_route_ends(coord_t sr, coord_t sc, coord_t gr, coord_t gc);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_START_ROW, sr);
		write_reg(CFG_START_COL, sc);
		write_reg(CFG_GOAL_ROW, gr);
		write_reg(CFG_GOAL_COL, gc);
	endtask

	function automatic cell_t pick_cost(int wall_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < wall_pct)
			return '0;
		roll = $urandom_range(9);
		if (roll == 0)
			return 8'd1;
		if (roll == 1)
			return 8'hFF;
		return cell_t'($urandom_range(255, 1));
	endfunction

	function automatic coord_t pick_coord();
		int roll;
		roll = $urandom_range(9);
		if (roll < 6)
			return coord_t'($urandom_range(7));
		return (roll < 8) ? 3'd0 : 3'd7;
	endfunction

	task automatic load_grid(int cells, int wall_pct);
		int i;
		for (i = 0; i < cells; i++)
			send_cell(pick_cost(wall_pct), i == cells - 1);
	endtask

	always @(posedge clk) begin
		if (arst_n && cell_bus.valid && !cell_bus.ready)
			stall_count <= stall_count + 1;
	end

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_asked != hold_given) begin
			hold_left  <= HOLD_CYCLES;
			hold_given <= hold_asked;
		end
	end

	task automatic check_route(cost_t got_cost, logic got_found);
		route_t want;
		if (route_q.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual cost %0d found %0b",
			         $time, got_cost, got_found);
			failures++;
		end else begin
			want = route_q.pop_front();
			if (want.found)
				reached++;
			else
				blocked++;
			if (got_cost !== want.cost) begin
				$display("%0t: path_cost mismatch: expected %0d, actual %0d",
				         $time, want.cost, got_cost);
				failures++;
			end
			if (got_found !== want.found) begin
				$display("%0t: path_found mismatch: expected %0b, actual %0b",
				         $time, want.found, got_found);
				failures++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			check_route(result_bus.path_cost, result_bus.path_found);
		result_bus.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
	end

	// every cell must be written once before any search may read it
	task automatic check_first_grid();
		int    i;
		cell_t cost;
		for (i = 0; i < CELL_COUNT; i++) begin
			if (i % 11 == 5)
				cost = '0;
			else if (i % 5 == 0)
				cost = 8'hFF;
			else if (i % 3 == 0)
				cost = 8'd1;
			else
				cost = cell_t'(i * 4 + 3);
			send_cell(cost, i == CELL_COUNT - 1);
		end
	endtask

	task automatic check_corner_ends();
		move_route_ends(3'd7, 3'd7, 3'd0, 3'd0);
		send_cell(8'hFF, 1'b1);
		move_route_ends(3'd0, 3'd7, 3'd7, 3'd0);
		send_cell(8'h80, 1'b1);
		move_route_ends(3'd7, 3'd0, 3'd0, 3'd7);
		send_cell(8'h7F, 1'b1);
	endtask

	task automatic check_same_cell();
		move_route_ends(3'd3, 3'd4, 3'd3, 3'd4);
		send_cell(8'd0, 1'b1);
	endtask

	task automatic check_wall_cases();
		// leave a walled start, then try to enter a walled goal
		move_route_ends(3'd0, 3'd0, 3'd0, 3'd1);
		send_cell(8'd0, 1'b0);
		send_cell(8'd17, 1'b1);
		send_cell(8'd5, 1'b0);
		send_cell(8'd0, 1'b1);
		move_route_ends(3'd0, 3'd1, 3'd0, 3'd1);
		send_cell(8'd3, 1'b0);
		send_cell(8'd0, 1'b1);
	endtask

	task automatic check_enclosed_start();
		int i;
		move_route_ends(3'd0, 3'd0, 3'd7, 3'd7);
		send_cell(8'd9, 1'b0);
		send_cell(8'd0, 1'b0);
		for (i = 2; i < GRID_SIDE; i++)
			send_cell(8'd50, 1'b0);
		send_cell(8'd0, 1'b1);
	endtask

	// stall the receiver so a result sits in the output register, the next
	// search waits behind it and the input backs up
	task automatic check_backpressure();
		int g;
		move_route_ends(3'd2, 3'd2, 3'd5, 3'd6);
		calm = 1'b1;
		hold_asked++;
		for (g = 0; g < 5; g++)
			load_grid(3, 0);
		calm = 1'b0;
		drain_results();
	endtask

	task automatic run_random_grids(int item_goal);
		int sent, cells, pick, wall_pct;
		sent = 0;
		while (sent < item_goal) begin
			if ($urandom_range(99) < 30)
				move_route_ends(pick_coord(), pick_coord(), pick_coord(), pick_coord());
			calm = (sent > item_goal * 2 / 5) && (sent < item_goal * 3 / 5);
			pick = $urandom_range(99);
			if (pick < 50)
				cells = $urandom_range(24, 1);
			else if (pick < 85)
				cells = CELL_COUNT;
			else
				cells = $urandom_range(CELL_COUNT + 26, CELL_COUNT + 1);
			case ($urandom_range(3))
				0:       wall_pct = 0;
				1:       wall_pct = 10;
				2:       wall_pct = 25;
				default: wall_pct = 45;
			endcase
			load_grid(cells, wall_pct);
			sent += cells;
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_START_ROW;
		cfg_data             = '0;
		cell_bus.valid       = 1'b0;
		cell_bus.cell_cost   = '0;
		cell_bus.last_cell   = 1'b0;
		result_bus.ready     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_first_grid();
		check_corner_ends();
		check_same_cell();
		check_wall_cases();
		check_enclosed_start();
		check_backpressure();
		run_random_grids(RANDOM_ITEMS);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Loaded %0d cells, ran %0d searches: %0d reached the goal, %0d blocked.",
		         cells_sent, searches, reached, blocked);
		$display("Input held off for %0d cycles; %0d mismatches.", stall_count, failures);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
